FILE: rtl/core/wpsp_pkg.sv
// ----------------------------------------------------------------------------
// WAV PCM stream parser package
// Shared result type, result codes and the header field helpers.
// ----------------------------------------------------------------------------
package wpsp_pkg;

   localparam int HdrLastPos = 43;
   localparam int RqDepth    = 4;
   localparam int RqAw       = 2;

   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_SAMPLE  = 2'd1,
      KIND_ERROR   = 2'd2,
      KIND_END     = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_SHORT    = 2'd1,
      ERR_NOT_PCM  = 2'd2,
      ERR_LAYOUT   = 2'd3
   } err_type;

   typedef enum logic [2:0] {
      PH_HEADER  = 3'b001,
      PH_SAMPLES = 3'b010,
      PH_DRAIN   = 3'b100
   } phase_type;

   typedef struct packed {
      kind_type           kind;
      logic signed [15:0] sample_value;
      logic               channel_index;
      logic [1:0]         channel_count;
      logic [30:0]        sample_rate;
      err_type            error_code;
      logic               final_result;
   } rsp_type;

   function automatic rsp_type res_header(input logic [1:0] count, input logic [30:0] rate);
      rsp_type r;
      r = '0;
      r.kind          = KIND_HEADER;
      r.channel_count = count;
      r.sample_rate   = rate;
      return r;
   endfunction

   function automatic rsp_type res_sample(input logic [15:0] value, input logic chan);
      rsp_type r;
      r = '0;
      r.kind          = KIND_SAMPLE;
      r.sample_value  = value;
      r.channel_index = chan;
      return r;
   endfunction

   function automatic rsp_type res_error(input err_type code);
      rsp_type r;
      r = '0;
      r.kind         = KIND_ERROR;
      r.error_code   = code;
      r.final_result = 1'b1;
      return r;
   endfunction

   function automatic rsp_type res_end();
      rsp_type r;
      r = '0;
      r.kind         = KIND_END;
      r.final_result = 1'b1;
      return r;
   endfunction

   // A whole frame fits in the remaining data budget.
   function automatic logic frame_fits(input logic [15:0] chan, input logic [15:0] fb,
                                       input logic [31:0] rem);
      return (chan != 16'd0) && (fb != 16'd0) && !fb[15] && (rem >= {16'd0, fb});
   endfunction

endpackage

FILE: rtl/core/wav_pcm_stream_parser.sv
// ----------------------------------------------------------------------------
// WAV PCM stream parser
// Takes a WAV file one byte per word, checks the 44-byte header and then
// gives the PCM data as signed Q1.15 samples. One byte is accepted in every
// cycle while req_ready is high. A byte that gives two results (the header
// or the last sample together with end of samples) pushes both into the
// four-entry result queue at once, and req_ready drops only while fewer
// than two entries are free. Results appear at the earliest in the cycle
// after the byte that causes them.
// ----------------------------------------------------------------------------
module wav_pcm_stream_parser
   import wpsp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_data_byte,
   input  logic               req_end_of_file,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_kind,
   output logic signed [15:0] rsp_sample_value,
   output logic               rsp_channel_index,
   output logic [1:0]         rsp_channel_count,
   output logic [30:0]        rsp_sample_rate,
   output logic [1:0]         rsp_error_code,
   output logic               rsp_final_result
);

   logic       accept;
   logic [1:0] push_count;
   rsp_type    res0, res1, out_word;
   logic       space_ok;

   assign req_ready = space_ok;
   assign accept    = req_valid && space_ok;

   wpsp_step u_step (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .data_byte   (req_data_byte),
      .end_of_file (req_end_of_file),
      .push_count  (push_count),
      .res0        (res0),
      .res1        (res1)
   );

   wpsp_out_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .res0       (res0),
      .res1       (res1),
      .space_ok   (space_ok),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_word   (out_word)
   );

   assign rsp_kind          = out_word.kind;
   assign rsp_sample_value  = out_word.sample_value;
   assign rsp_channel_index = out_word.channel_index;
   assign rsp_channel_count = out_word.channel_count;
   assign rsp_sample_rate   = out_word.sample_rate;
   assign rsp_error_code    = out_word.error_code;
   assign rsp_final_result  = out_word.final_result;

endmodule

FILE: rtl/core/wpsp_step.sv
// ----------------------------------------------------------------------------
// WAV PCM stream parser step logic
// Holds the parse state and turns each accepted byte into up to two results.
// ----------------------------------------------------------------------------
module wpsp_step
   import wpsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] data_byte,
   input  logic       end_of_file,
   output logic [1:0] push_count,
   output rsp_type    res0,
   output rsp_type    res1
);

   logic [5:0]  pos_ff, pos_in;
   phase_type   phase_ff, phase_in;
   logic [31:0] fmt_ff, fmt_in;
   logic [15:0] tag_ff, tag_in;
   logic [15:0] chan_ff, chan_in;
   logic [31:0] rate_ff, rate_in;
   logic [15:0] fb_ff, fb_in;
   logic [15:0] bits_ff, bits_in;
   logic [31:0] rem_ff, rem_in;
   logic        cc_ff, cc_in;
   logic [7:0]  hold_ff, hold_in;
   logic        bis_ff, bis_in;

   logic [1:0]  n;
   rsp_type     r0, r1;
   err_type     herr;
   logic        have;
   logic [15:0] val;
   logic [1:0]  cc_plus;

   always_comb begin
      pos_in   = pos_ff;
      phase_in = phase_ff;
      fmt_in   = fmt_ff;
      tag_in   = tag_ff;
      chan_in  = chan_ff;
      rate_in  = rate_ff;
      fb_in    = fb_ff;
      bits_in  = bits_ff;
      rem_in   = rem_ff;
      cc_in    = cc_ff;
      hold_in  = hold_ff;
      bis_in   = bis_ff;
      n        = 2'd0;
      r0       = '0;
      r1       = '0;
      herr     = ERR_NONE;
      have     = 1'b0;
      val      = 16'd0;
      cc_plus  = {1'b0, cc_ff} + 2'd1;

      unique case (phase_ff)
         PH_HEADER: begin
            if (pos_ff[5:2] == 4'd4) fmt_in[8*pos_ff[1:0] +: 8] = data_byte;
            if (pos_ff[5:1] == 5'd10) tag_in[8*pos_ff[0] +: 8] = data_byte;
            if (pos_ff[5:1] == 5'd11) chan_in[8*pos_ff[0] +: 8] = data_byte;
            if (pos_ff[5:2] == 4'd6) rate_in[8*pos_ff[1:0] +: 8] = data_byte;
            if (pos_ff[5:1] == 5'd16) fb_in[8*pos_ff[0] +: 8] = data_byte;
            if (pos_ff[5:1] == 5'd17) bits_in[8*pos_ff[0] +: 8] = data_byte;
            if (pos_ff[5:2] == 4'd10) rem_in[8*pos_ff[1:0] +: 8] = data_byte;
            pos_in = pos_ff + 6'd1;
            if (pos_ff == 6'(HdrLastPos)) begin
               if ((!fmt_in[31] && fmt_in > 32'd16) || tag_in != 16'd1) begin
                  herr = ERR_NOT_PCM;
               end else if (rem_in[31] || chan_in[15] || chan_in > 16'd2 ||
                            (bits_in != 16'd8 && bits_in != 16'd16) || fb_in == 16'd0) begin
                  herr = ERR_LAYOUT;
               end
               if (herr != ERR_NONE) begin
                  r0       = res_error(herr);
                  n        = 2'd1;
                  phase_in = PH_DRAIN;
               end else begin
                  r0 = res_header(chan_in[1:0], rate_in[30:0]);
                  n  = 2'd1;
                  if (!frame_fits(chan_in, fb_in, rem_in)) begin
                     r1       = res_end();
                     n        = 2'd2;
                     phase_in = PH_DRAIN;
                  end else begin
                     rem_in   = rem_in - {16'd0, fb_in};
                     phase_in = PH_SAMPLES;
                     if (end_of_file) begin
                        r1 = res_end();
                        n  = 2'd2;
                     end
                  end
               end
            end else if (end_of_file) begin
               r0 = res_error(ERR_SHORT);
               n  = 2'd1;
            end
         end
         PH_SAMPLES: begin
            if (bits_ff == 16'd8) begin
               val  = {data_byte ^ 8'h80, 8'h00};
               have = 1'b1;
            end else if (!bis_ff) begin
               hold_in = data_byte;
               bis_in  = 1'b1;
            end else begin
               val    = {data_byte, hold_ff};
               bis_in = 1'b0;
               have   = 1'b1;
            end
            if (have) begin
               r0 = res_sample(val, cc_ff);
               n  = 2'd1;
               if (cc_plus >= chan_ff[1:0]) begin
                  cc_in = 1'b0;
                  if (frame_fits(chan_ff, fb_ff, rem_ff)) begin
                     rem_in = rem_ff - {16'd0, fb_ff};
                  end else begin
                     r1       = res_end();
                     n        = 2'd2;
                     phase_in = PH_DRAIN;
                  end
               end else begin
                  cc_in = 1'b1;
               end
            end
            if (phase_in == PH_SAMPLES && end_of_file) begin
               if (have) begin
                  r1 = res_end();
                  n  = 2'd2;
               end else begin
                  r0 = res_end();
                  n  = 2'd1;
               end
            end
         end
         PH_DRAIN: begin
         end
         default: begin
         end
      endcase

      if (end_of_file) begin
         pos_in   = 6'd0;
         phase_in = PH_HEADER;
         fmt_in   = 32'd0;
         tag_in   = 16'd0;
         chan_in  = 16'd0;
         rate_in  = 32'd0;
         fb_in    = 16'd0;
         bits_in  = 16'd0;
         rem_in   = 32'd0;
         cc_in    = 1'b0;
         hold_in  = 8'd0;
         bis_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= 6'd0;
         phase_ff <= PH_HEADER;
         fmt_ff   <= 32'd0;
         tag_ff   <= 16'd0;
         chan_ff  <= 16'd0;
         rate_ff  <= 32'd0;
         fb_ff    <= 16'd0;
         bits_ff  <= 16'd0;
         rem_ff   <= 32'd0;
         cc_ff    <= 1'b0;
         hold_ff  <= 8'd0;
         bis_ff   <= 1'b0;
      end else if (accept) begin
         pos_ff   <= pos_in;
         phase_ff <= phase_in;
         fmt_ff   <= fmt_in;
         tag_ff   <= tag_in;
         chan_ff  <= chan_in;
         rate_ff  <= rate_in;
         fb_ff    <= fb_in;
         bits_ff  <= bits_in;
         rem_ff   <= rem_in;
         cc_ff    <= cc_in;
         hold_ff  <= hold_in;
         bis_ff   <= bis_in;
      end
   end

   assign push_count = accept ? n : 2'd0;
   assign res0       = r0;
   assign res1       = r1;

   // The last byte of a file always leaves the parser ready for a new header.
   a_eof_restart: assert property (@(posedge clock) disable iff (reset)
      accept && end_of_file |=> phase_ff == PH_HEADER && pos_ff == 6'd0)
      else $error("parser did not restart after end of file");

   // Sample words are only produced for a mono or stereo layout.
   a_samples_layout: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SAMPLES |-> (chan_ff == 16'd1 || chan_ff == 16'd2))
      else $error("sample phase with unsupported channel count");

   // When a byte gives two results, the second one closes the file.
   a_pair_final: assert property (@(posedge clock) disable iff (reset)
      push_count == 2'd2 |-> res1.final_result && res1.kind == KIND_END)
      else $error("second result of a byte is not end of samples");

endmodule

FILE: rtl/core/wpsp_out_queue.sv
// ----------------------------------------------------------------------------
// WAV PCM stream parser result queue
// Four-entry queue taking up to two results per cycle, giving one on out_ready.
// ----------------------------------------------------------------------------
module wpsp_out_queue
   import wpsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [1:0] push_count,
   input  rsp_type    res0,
   input  rsp_type    res1,
   output logic       space_ok,
   output logic       out_valid,
   input  logic       out_ready,
   output rsp_type    out_word
);

   rsp_type         mem_ff [RqDepth];
   logic [RqAw-1:0] wr_ff, wr_in;
   logic [RqAw-1:0] rd_ff, rd_in;
   logic [RqAw:0]   count_ff, count_in;
   logic            pop;

   assign out_valid = (count_ff != '0);
   assign out_word  = mem_ff[rd_ff];
   assign pop       = out_valid && out_ready;
   assign space_ok  = (count_ff <= (RqAw+1)'(RqDepth - 2));

   assign wr_in    = wr_ff + RqAw'(push_count);
   assign rd_in    = rd_ff + RqAw'(pop);
   assign count_in = count_ff + (RqAw+1)'(push_count) - (RqAw+1)'(pop);

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem_ff[wr_ff] <= res0;
      end
      if (push_count == 2'd2) begin
         mem_ff[wr_ff + RqAw'(1)] <= res1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (RqAw+1)'(RqDepth))
      else $error("result queue over capacity");

   a_pair_room: assert property (@(posedge clock) disable iff (reset)
      push_count == 2'd2 |-> count_ff <= (RqAw+1)'(RqDepth - 2))
      else $error("two results pushed without room");

   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      pop && push_count == 2'd0 |=> count_ff == $past(count_ff) - (RqAw+1)'(1))
      else $error("queue count did not drop on a lone pop");

endmodule
